/* rtl/core/tte_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tap tempo estimator package
// Shared sizes, register indexes and reset values for the tap tempo estimator.
// ----------------------------------------------------------------------------
package tte_pkg;

  localparam int unsigned WINDOW_TAPS = 8;

  localparam int unsigned SLOT_W = (WINDOW_TAPS > 1) ? $clog2(WINDOW_TAPS) : 1;
  localparam int unsigned CNT_W  = $clog2(WINDOW_TAPS + 1);

  localparam int unsigned STAMP_W = 32;
  localparam int unsigned TEMPO_W = 13;
  localparam int unsigned STEP_W  = 6;
  localparam int unsigned TOUT_W  = 16;
  localparam int unsigned HELD_W  = 4;
  localparam int unsigned CFG_W   = 16;

  // Tempo numerator: 60000 ms per minute times 16 fractional steps per BPM.
  localparam int unsigned TEMPO_NUM   = 960000;
  localparam int unsigned DVD_MAX     = TEMPO_NUM * (WINDOW_TAPS - 1);
  localparam int unsigned DVD_W       = $clog2(DVD_MAX + 1);
  localparam int unsigned DIV_CNT_W   = $clog2(DVD_W + 1);

  // Nudge arithmetic is done signed in this width.
  localparam int unsigned NUD_W = TEMPO_W + 2;

  typedef enum logic [1:0] {
    CFG_TIMEOUT   = 2'd0,
    CFG_TEMPO_MIN = 2'd1,
    CFG_TEMPO_MAX = 2'd2,
    CFG_UNUSED    = 2'd3
  } cfg_idx_e;

  localparam logic [TOUT_W-1:0]  TIMEOUT_RST   = 16'd3000;
  localparam logic [TEMPO_W-1:0] TEMPO_MIN_RST = 13'd320;
  localparam logic [TEMPO_W-1:0] TEMPO_MAX_RST = 13'd4480;
  localparam logic [TEMPO_W-1:0] TEMPO_RST     = 13'd1920;

endpackage

/* rtl/core/tte_div.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tap tempo serial divider
// Restoring divider that produces one quotient bit per cycle.
// ----------------------------------------------------------------------------
module tte_div (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [tte_pkg::DVD_W-1:0]     dividend_i,
  input  logic [tte_pkg::STAMP_W-1:0]   divisor_i,
  output logic                          done_o,
  output logic [tte_pkg::DVD_W-1:0]     quotient_o
);
  import tte_pkg::*;

  logic                  busy_q;
  logic                  done_q;
  logic [DIV_CNT_W-1:0]  cnt_q;
  logic [STAMP_W-1:0]    rem_q;
  logic [DVD_W-1:0]      quo_q;

  logic [STAMP_W:0]      rem_sh;
  logic                  ge;
  logic [STAMP_W:0]      rem_sub;

  // The remainder stays below the divisor, so the shifted value fits 33 bits.
  assign rem_sh  = {rem_q, quo_q[DVD_W-1]};
  assign ge      = rem_sh >= {1'b0, divisor_i};
  assign rem_sub = rem_sh - {1'b0, divisor_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      rem_q  <= '0;
      quo_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= DIV_CNT_W'(DVD_W);
        rem_q  <= '0;
        quo_q  <= dividend_i;
      end else if (busy_q) begin
        rem_q <= ge ? rem_sub[STAMP_W-1:0] : rem_sh[STAMP_W-1:0];
        quo_q <= {quo_q[DVD_W-2:0], ge};
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == DIV_CNT_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

/* rtl/core/tap_tempo_estimator.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tap tempo estimator
// Averages the interval over the last taps into a tempo in 1/16 BPM, and
// applies whole-BPM nudges with clamping.
// ----------------------------------------------------------------------------
//
//   channel | direction | handshake               | payload
//   --------+-----------+-------------------------+------------------------------
//   in      | sink      | in_valid_i / in_stall_o | func_i, stamp_ms_i, step_bpm_i
//   out     | source    | out_valid_o/out_stall_i | tempo_q4_o, tempo_updated_o,
//           |           |                         | taps_held_o
//   cfg     | sink      | cfg_we_i                | cfg_idx_i, cfg_wdata_i
//
// A nudge beat goes through S_NUDGE, and a tap through S_TAP and S_SPAN and,
// when it runs the bit-serial divider, through S_DIV; S_DONE then registers the
// result, and the next beat is taken back in S_IDLE.
// The block takes a new beat once its previous result is in the output
// register, even while that result is stalled. Reset restores the tempo to
// 120 BPM, empties the tap window and loads the register defaults.
// ----------------------------------------------------------------------------
module tap_tempo_estimator (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic                                func_i,
  input  logic [tte_pkg::STAMP_W-1:0]         stamp_ms_i,
  input  logic signed [tte_pkg::STEP_W-1:0]   step_bpm_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic [tte_pkg::TEMPO_W-1:0]         tempo_q4_o,
  output logic                                tempo_updated_o,
  output logic [tte_pkg::HELD_W-1:0]          taps_held_o,
  input  logic                                cfg_we_i,
  input  logic [1:0]                          cfg_idx_i,
  input  logic [tte_pkg::CFG_W-1:0]           cfg_wdata_i
);
  import tte_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_NUDGE,
    S_TAP,
    S_SPAN,
    S_DIV,
    S_DONE
  } state_e;

  state_e               state_q;
  logic [STAMP_W-1:0]   stamp_q;
  logic [STEP_W-1:0]    step_q;
  logic [SLOT_W-1:0]    slot_q;
  logic [CNT_W-1:0]     total_q;
  logic [TEMPO_W-1:0]   tempo_q;
  logic                 upd_q;
  logic [STAMP_W-1:0]   span_q;
  logic [TOUT_W-1:0]    timeout_q;
  logic [TEMPO_W-1:0]   tmin_q;
  logic [TEMPO_W-1:0]   tmax_q;
  logic                 out_valid_q;
  logic [TEMPO_W-1:0]   out_tempo_q;
  logic                 out_upd_q;
  logic [HELD_W-1:0]    out_held_q;

  logic [STAMP_W-1:0]   ring_q [WINDOW_TAPS];

  // Ring addressing.
  logic [SLOT_W-1:0]    prev_idx;
  logic [CNT_W:0]       old_sum;
  logic [SLOT_W-1:0]    old_idx;
  logic [SLOT_W-1:0]    rd_idx;
  logic [STAMP_W-1:0]   rd_data;

  // Tap bookkeeping.
  logic [STAMP_W-1:0]   gap;
  logic                 restart;
  logic [SLOT_W-1:0]    eff_slot;
  logic [CNT_W-1:0]     eff_total;
  logic [SLOT_W-1:0]    next_slot;
  logic                 ring_we;

  // Division and nudge arithmetic.
  logic                 div_start;
  logic                 div_done;
  logic [DVD_W-1:0]     dividend;
  logic [DVD_W-1:0]     quotient;
  logic [STAMP_W-1:0]   span;
  logic                 cand_ok;
  logic signed [NUD_W-1:0] nud_sum;
  logic signed [NUD_W-1:0] nud_max;
  logic signed [NUD_W-1:0] nud_min;
  logic signed [NUD_W-1:0] nud_clamp;
  logic [CNT_W+HELD_W-1:0] held_ext;
  logic                 out_free;

  assign prev_idx = (slot_q == '0) ? SLOT_W'(WINDOW_TAPS - 1) : slot_q - 1'b1;

  // Oldest held tap is total taps back from the write slot, modulo the window.
  assign old_sum = (CNT_W+1)'(slot_q) + (CNT_W+1)'(WINDOW_TAPS) - (CNT_W+1)'(total_q);
  assign old_idx = (old_sum >= (CNT_W+1)'(WINDOW_TAPS)) ?
                   SLOT_W'(old_sum - (CNT_W+1)'(WINDOW_TAPS)) : SLOT_W'(old_sum);

  assign rd_idx  = (state_q == S_TAP) ? prev_idx : old_idx;
  assign rd_data = ring_q[rd_idx];

  assign gap       = stamp_q - rd_data;
  assign restart   = (total_q != '0) && (gap > {{(STAMP_W-TOUT_W){1'b0}}, timeout_q});
  assign eff_slot  = restart ? '0 : slot_q;
  assign eff_total = restart ? '0 : total_q;
  assign next_slot = (eff_slot == SLOT_W'(WINDOW_TAPS - 1)) ? '0 : eff_slot + 1'b1;
  assign ring_we   = (state_q == S_TAP);

  assign span      = stamp_q - rd_data;
  assign dividend  = DVD_W'(TEMPO_NUM) * DVD_W'(total_q - 1'b1);
  assign div_start = (state_q == S_SPAN) && (total_q >= CNT_W'(2)) && (span != '0);

  assign cand_ok = (quotient >= {{(DVD_W-TEMPO_W){1'b0}}, tmin_q}) &&
                   (quotient <= {{(DVD_W-TEMPO_W){1'b0}}, tmax_q});

  // Nudge: add step*16, clamp to max, then to min, then at zero.
  assign nud_sum = $signed({2'b00, tempo_q}) +
                   $signed({{(NUD_W-STEP_W-4){step_q[STEP_W-1]}}, step_q, 4'b0000});
  assign nud_max = (nud_sum > $signed({2'b00, tmax_q})) ? $signed({2'b00, tmax_q}) : nud_sum;
  assign nud_min = (nud_max < $signed({2'b00, tmin_q})) ? $signed({2'b00, tmin_q}) : nud_max;
  assign nud_clamp = (nud_min < 0) ? '0 : nud_min;

  assign held_ext = {{HELD_W{1'b0}}, total_q};
  assign out_free = !out_valid_q || !out_stall_i;

  tte_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (dividend),
    .divisor_i  (span_q),
    .done_o     (div_done),
    .quotient_o (quotient)
  );

  always_ff @(posedge clk_i) begin
    if (ring_we) begin
      ring_q[eff_slot] <= stamp_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timeout_q <= TIMEOUT_RST;
      tmin_q    <= TEMPO_MIN_RST;
      tmax_q    <= TEMPO_MAX_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_TIMEOUT:   timeout_q <= cfg_wdata_i;
        CFG_TEMPO_MIN: tmin_q    <= cfg_wdata_i[TEMPO_W-1:0];
        CFG_TEMPO_MAX: tmax_q    <= cfg_wdata_i[TEMPO_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      stamp_q     <= '0;
      step_q      <= '0;
      slot_q      <= '0;
      total_q     <= '0;
      tempo_q     <= TEMPO_RST;
      upd_q       <= 1'b0;
      span_q      <= '0;
      out_valid_q <= 1'b0;
      out_tempo_q <= '0;
      out_upd_q   <= 1'b0;
      out_held_q  <= '0;
    end else begin
      if ((state_q == S_DONE) && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            stamp_q <= stamp_ms_i;
            step_q  <= step_bpm_i;
            upd_q   <= 1'b0;
            state_q <= func_i ? S_NUDGE : S_TAP;
          end
        end
        S_NUDGE: begin
          tempo_q <= nud_clamp[TEMPO_W-1:0];
          total_q <= '0;
          slot_q  <= '0;
          upd_q   <= 1'b1;
          state_q <= S_DONE;
        end
        S_TAP: begin
          slot_q  <= next_slot;
          total_q <= (eff_total < CNT_W'(WINDOW_TAPS)) ? eff_total + 1'b1 : eff_total;
          state_q <= S_SPAN;
        end
        S_SPAN: begin
          span_q  <= span;
          state_q <= div_start ? S_DIV : S_DONE;
        end
        S_DIV: begin
          if (div_done) begin
            if (cand_ok) begin
              tempo_q <= quotient[TEMPO_W-1:0];
              upd_q   <= 1'b1;
            end
            state_q <= S_DONE;
          end
        end
        S_DONE: begin
          if (out_free) begin
            out_tempo_q <= tempo_q;
            out_upd_q   <= upd_q;
            out_held_q  <= held_ext[HELD_W-1:0];
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign in_stall_o      = (state_q != S_IDLE);
  assign out_valid_o     = out_valid_q;
  assign tempo_q4_o      = out_tempo_q;
  assign tempo_updated_o = out_upd_q;
  assign taps_held_o     = out_held_q;

endmodule
